### hdl/grace_period_quiescent_tree_unit_assert.svh
// assertion macros used by the checker file
`ifndef GRACE_PERIOD_QUIESCENT_TREE_UNIT_ASSERT_SVH
`define GRACE_PERIOD_QUIESCENT_TREE_UNIT_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define GPQT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies the consequent at the next edge
`define GPQT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/gpqt_pkg.sv
// constants, types and codes of the grace-period tracker
package gpqt_pkg;

  localparam int FANOUT     = 64;
  localparam int MAX_LEAVES = 4;
  localparam int NEST_WIDTH = 8;
  localparam int CPU_SLOTS  = 256;

  localparam int CPU_W    = 8;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 9;
  localparam int SEQ_W    = 32;
  localparam int LEAF_W   = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
  localparam int BIT_W    = $clog2(FANOUT);
  localparam int CPU_LIMIT = (MAX_LEAVES * FANOUT > CPU_SLOTS) ? CPU_SLOTS
                                                               : MAX_LEAVES * FANOUT;

  localparam logic [NEST_WIDTH-1:0] NEST_MAX = '1;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOCK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNLOCK  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd3;

  // apb register map
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_CPU_TOTAL = 1'b0;

  typedef logic [NEST_WIDTH-1:0] depth_t;
  typedef logic [MAX_LEAVES-1:0][FANOUT-1:0] leaf_masks_t;

  // write request into the nesting store
  typedef struct packed {
    logic             en;
    logic [CPU_W-1:0] addr;
    depth_t           data;
  } nest_wr_t;

endpackage

### hdl/gpqt_if.sv
// request and result channels of the grace-period tracker
interface gpqt_event_if import gpqt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CPU_W-1:0]  cpu_index;

  modport source (output valid, kind, cpu_index, input ready);
  modport sink (input valid, kind, cpu_index, output ready);
endinterface

interface gpqt_result_if import gpqt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] sequence_number;
  logic             period_active;
  logic             period_finished;
  logic             reported;
  logic             nesting_fault;

  modport source (output valid, sequence_number, period_active, period_finished,
                  reported, nesting_fault, input ready);
  modport sink (input valid, sequence_number, period_active, period_finished,
                reported, nesting_fault, output ready);
endinterface

### hdl/gpqt_nest_store.sv
// per-cpu read nesting depth store with registered read and reset-valid bits
module gpqt_nest_store import gpqt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [CPU_W-1:0] rd_addr,
  output depth_t           rd_depth,
  input  nest_wr_t         wr
);

  depth_t               mem [CPU_SLOTS];
  logic [CPU_SLOTS-1:0] written;
  depth_t               rd_data;
  logic                 rd_written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data    <= mem[rd_addr];
      rd_written <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  // entries never written since reset read as zero depth
  assign rd_depth = rd_written ? rd_data : '0;

endmodule

### hdl/grace_period_quiescent_tree_unit.sv
// top level of the hierarchical grace-period quiescent-state tracker
//
// usage
//   events  : request channel, one event per request (kind, cpu_index);
//             kinds are grace-period request, read lock, read unlock, tick
//   results : one result per event: sequence number, period active,
//             period finished, reported, nesting fault
//   apb     : one register, the cpu total at byte address 0, written by the user
//             only while no request is in flight (not enforced); pready is always high
// timing
//   a request is taken into the input stage, its nesting depth is read from
//   the depth store at the same edge, and the whole update runs in the next
//   cycle into the result register unless results.ready holds it off; one
//   request per cycle sustained while results.ready stays high, set by the
//   read-modify-write of the depth store (forwarded between neighbours)
// reset
//   rst clears masks, sequence, pending flags, latched request and all
//   nesting depths (through the store's per-entry written bits); the cpu
//   total returns to 1; no clearing sweep is needed
// stalls
//   while results.ready is low the result register holds; one more request
//   waits in the input stage, after which events.ready drops
module grace_period_quiescent_tree_unit import gpqt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  gpqt_event_if.sink          events,
  gpqt_result_if.source       results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // configuration register
  logic [COUNT_W-1:0] cpu_total;
  logic               reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_CPU_TOTAL);
  assign prdata  = reg_hit ? PDATA_W'(cpu_total) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_total <= COUNT_W'(1);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      cpu_total <= pwdata[COUNT_W-1:0];
    end
  end

  // tracker state
  leaf_masks_t          leaf_masks, leaf_masks_next;
  logic [MAX_LEAVES-1:0] root_mask, root_mask_next;
  logic [SEQ_W-1:0]     gp_sequence, gp_sequence_next;
  logic [CPU_SLOTS-1:0] pending, pending_next;
  logic                 request_latched, request_latched_next;

  // input stage
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [CPU_W-1:0]  s1_cpu;
  logic              s1_go;
  logic              in_fire;

  // last depth written, covers the store read that raced with it
  logic              fwd_valid;
  logic [CPU_W-1:0]  fwd_cpu;
  depth_t            fwd_depth;

  depth_t   store_depth;
  depth_t   depth;
  nest_wr_t nest_wr;

  assign s1_go        = s1_valid && (!results.valid || results.ready);
  assign events.ready = !s1_valid || s1_go;
  assign in_fire      = events.valid && events.ready;

  gpqt_nest_store u_nest (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_fire),
    .rd_addr  (events.cpu_index),
    .rd_depth (store_depth),
    .wr       (nest_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_kind <= KIND_REQUEST;
      s1_cpu  <= '0;
    end else if (in_fire) begin
      s1_kind <= events.kind;
      s1_cpu  <= events.cpu_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (nest_wr.en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (nest_wr.en) begin
      fwd_cpu   <= nest_wr.addr;
      fwd_depth <= nest_wr.data;
    end
  end

  assign depth = (fwd_valid && fwd_cpu == s1_cpu) ? fwd_depth : store_depth;

  // masks loaded when a period starts, from the saturated cpu count
  logic [COUNT_W-1:0]    count_sat;
  leaf_masks_t           start_leaf;
  logic [MAX_LEAVES-1:0] start_root;
  logic [CPU_SLOTS-1:0]  start_pending;

  always_comb begin
    if (cpu_total == '0) begin
      count_sat = COUNT_W'(1);
    end else if (cpu_total > COUNT_W'(CPU_LIMIT)) begin
      count_sat = COUNT_W'(CPU_LIMIT);
    end else begin
      count_sat = cpu_total;
    end
    for (int l = 0; l < MAX_LEAVES; l++) begin
      start_root[l] = (count_sat > COUNT_W'(l * FANOUT));
      for (int j = 0; j < FANOUT; j++) begin
        start_leaf[l][j] = (COUNT_W'(l * FANOUT + j) < count_sat);
      end
    end
    for (int i = 0; i < CPU_SLOTS; i++) begin
      start_pending[i] = (COUNT_W'(i) < count_sat);
    end
  end

  // where the event's cpu sits in the tree
  logic [CPU_W-1:0]  leaf_full;
  logic              leaf_ok;
  logic [LEAF_W-1:0] leaf_sel;
  logic [BIT_W-1:0]  bit_idx;

  assign leaf_full = CPU_W'(s1_cpu / FANOUT);
  assign leaf_ok   = (leaf_full < CPU_W'(MAX_LEAVES));
  assign leaf_sel  = leaf_full[LEAF_W-1:0];
  assign bit_idx   = BIT_W'(s1_cpu % FANOUT);

  // single-pass event update
  logic do_report;
  logic start;
  logic fault;
  logic finished;

  always_comb begin
    leaf_masks_next      = leaf_masks;
    root_mask_next       = root_mask;
    gp_sequence_next     = gp_sequence;
    pending_next         = pending;
    request_latched_next = request_latched;
    do_report            = 1'b0;
    start                = 1'b0;
    fault                = 1'b0;
    finished             = 1'b0;
    nest_wr              = '0;
    nest_wr.addr         = s1_cpu;

    unique case (s1_kind)
      KIND_REQUEST: begin
        request_latched_next = 1'b1;
        start = (root_mask == '0);
      end
      KIND_LOCK: begin
        if (depth == NEST_MAX) begin
          fault = 1'b1;
        end else begin
          nest_wr.en   = 1'b1;
          nest_wr.data = depth + depth_t'(1);
        end
      end
      KIND_UNLOCK: begin
        if (depth == '0) begin
          fault = 1'b1;
        end else begin
          nest_wr.en   = 1'b1;
          nest_wr.data = depth - depth_t'(1);
          // outermost unlock of a pending cpu
          do_report = (depth == depth_t'(1)) && pending[s1_cpu];
        end
      end
      KIND_TICK: begin
        do_report = pending[s1_cpu] && (depth == '0);
      end
      default: begin
      end
    endcase

    if (do_report) begin
      pending_next[s1_cpu] = 1'b0;
      if (leaf_ok && leaf_masks[leaf_sel][bit_idx]) begin
        leaf_masks_next[leaf_sel][bit_idx] = 1'b0;
        if (leaf_masks_next[leaf_sel] == '0 && root_mask[leaf_sel]) begin
          root_mask_next[leaf_sel] = 1'b0;
          finished = (root_mask_next == '0);
        end
      end
      // back-to-back period when a request waits
      if (finished && request_latched) begin
        start = 1'b1;
      end
    end

    if (start) begin
      request_latched_next = 1'b0;
      gp_sequence_next     = gp_sequence + SEQ_W'(1);
      root_mask_next       = start_root;
      leaf_masks_next      = start_leaf;
      pending_next         = start_pending;
    end

    // no side effects unless the event really commits
    nest_wr.en = nest_wr.en && s1_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_masks      <= '0;
      root_mask       <= '0;
      gp_sequence     <= '0;
      pending         <= '0;
      request_latched <= 1'b0;
    end else if (s1_go) begin
      leaf_masks      <= leaf_masks_next;
      root_mask       <= root_mask_next;
      gp_sequence     <= gp_sequence_next;
      pending         <= pending_next;
      request_latched <= request_latched_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (s1_go) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      results.sequence_number <= gp_sequence_next;
      results.period_active   <= (root_mask_next != '0);
      results.period_finished <= finished;
      results.reported        <= do_report;
      results.nesting_fault   <= fault;
    end
  end

endmodule

### hdl/gpqt_checker.sv
// port-level checks of the grace-period tracker, bound to the top level
`include "grace_period_quiescent_tree_unit_assert.svh"

module gpqt_checker import gpqt_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input logic [SEQ_W-1:0] seq,
  input logic             active,
  input logic             finished,
  input logic             reported,
  input logic             fault
);

  logic             res_fire;
  logic [SEQ_W-1:0] last_seq;

  assign res_fire = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq <= '0;
    end else if (res_fire) begin
      last_seq <= seq;
    end
  end

  `GPQT_ASSERT_ALWAYS(a_finish_needs_report, !(res_valid && finished) || reported, "period finished without a report")
  `GPQT_ASSERT_ALWAYS(a_report_not_fault, !(res_valid && reported && fault), "report and nesting fault together")
  `GPQT_ASSERT_ALWAYS(a_seq_steps_by_one, !res_fire || seq == last_seq || seq == last_seq + SEQ_W'(1), "sequence number jumped")
  `GPQT_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(seq) && $stable(active) && $stable(finished), "stalled result changed")

endmodule

bind grace_period_quiescent_tree_unit gpqt_checker u_gpqt_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .seq       (results.sequence_number),
  .active    (results.period_active),
  .finished  (results.period_finished),
  .reported  (results.reported),
  .fault     (results.nesting_fault)
);
